// ===== rtl/core/hss_pkg.sv =====
package hss_pkg;

  localparam int SNAPSHOT_BYTES_DEF = 512;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] KIND_SAVE  = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LEN_REJ  = 3'd1;
  localparam logic [2:0] ST_NO_VALID = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_RUN_ERR  = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_in;
    logic [15:0] declared_len;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  status;
    logic [31:0] hash_out;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } hss_cmd_t;

  // multiply by the sparse prime 2^24 + 0x193 with shifts and adds
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    begin
      x = h ^ {24'd0, b};
      fnv_step = x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
    end
  endfunction

endpackage

// ===== rtl/core/hashed_snapshot_store.sv =====
// Snapshot store with FNV-1a 32-bit integrity hash.
// Input channel in_valid/in_ready/in_data carries one transaction per byte:
// save byte, load byte or clear. Output channel out_valid/out_ready/out_data
// returns exactly one result transaction per input transaction, in order.
// A save run writes SNAPSHOT_BYTES bytes and commits the hash on its last
// transaction; a load run reads them back and flags a hash mismatch on its
// last transaction. A wrong declared length is rejected without access.
// The accept edge registers the transaction and the memory read; the hash step
// and the result are registered in the sequencer's execute (hash/update) state
// that follows. No new transaction is accepted while the sequencer is in that
// state, so each capture is followed by its hash/update before the next capture.
// Reset clears the valid mark, stored hash and run tracking; memory contents
// stay undefined until a save run writes them.
// While a result is pending and out_ready is low, it is held and no new input is accepted;
// the next input may be accepted in the same cycle the held result is taken.
module hashed_snapshot_store
  import hss_pkg::*;
#(
  parameter int SNAPSHOT_BYTES = SNAPSHOT_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  hss_cmd_t cmd;

  hss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hss_dp #(
    .SNAPSHOT_BYTES (SNAPSHOT_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/hss_ctrl.sv =====
module hss_ctrl
  import hss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output hss_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/hss_dp.sv =====
module hss_dp
  import hss_pkg::*;
#(
  parameter int SNAPSHOT_BYTES = SNAPSHOT_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  hss_cmd_t  cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  localparam int PW = $clog2(SNAPSHOT_BYTES + 1);
  localparam int AW = (SNAPSHOT_BYTES > 1) ? $clog2(SNAPSHOT_BYTES) : 1;
  localparam logic [PW-1:0] POS_FULL = PW'(SNAPSHOT_BYTES);
  localparam logic [15:0]   LEN_OK   = 16'(SNAPSHOT_BYTES);

  logic [7:0] mem [SNAPSHOT_BYTES];

  in_item_t    item_r;
  logic [7:0]  rd_data_r;
  out_item_t   out_r, out_nxt;

  logic [31:0] stored_hash_r, stored_hash_nxt;
  logic        valid_r, valid_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic        failed_r, failed_nxt;
  logic        active_r, active_nxt;
  logic [1:0]  run_kind_r, run_kind_nxt;

  logic          restart_in;
  logic [PW-1:0] rd_pos;

  logic          restart;
  logic [PW-1:0] pos_eff;
  logic [31:0]   hash_eff;
  logic          failed_eff;
  logic [7:0]    hash_byte;
  logic          wr_en;

  assign restart_in = !active_r || (run_kind_r != in_data.kind);
  assign rd_pos     = restart_in ? '0 : pos_r;
  assign restart    = !active_r || (run_kind_r != item_r.kind);

  always_comb begin
    out_nxt         = '0;
    stored_hash_nxt = stored_hash_r;
    valid_nxt       = valid_r;
    pos_nxt         = pos_r;
    hash_nxt        = hash_r;
    failed_nxt      = failed_r;
    active_nxt      = active_r;
    run_kind_nxt    = run_kind_r;
    pos_eff         = restart ? '0 : pos_r;
    hash_eff        = restart ? FNV_BASIS : hash_r;
    failed_eff      = restart ? 1'b0 : failed_r;
    hash_byte       = (item_r.kind == KIND_SAVE) ? item_r.byte_in : rd_data_r;
    wr_en           = 1'b0;

    if (item_r.kind == KIND_CLEAR) begin
      valid_nxt       = 1'b0;
      stored_hash_nxt = '0;
      active_nxt      = 1'b0;
      pos_nxt         = '0;
      hash_nxt        = FNV_BASIS;
      failed_nxt      = 1'b0;
    end else if (item_r.kind == KIND_SAVE || item_r.kind == KIND_LOAD) begin
      out_nxt.last_out = item_r.last;
      if (item_r.declared_len != LEN_OK) begin
        out_nxt.status = ST_LEN_REJ;
        active_nxt     = 1'b0;
        pos_nxt        = '0;
        hash_nxt       = FNV_BASIS;
        failed_nxt     = 1'b0;
      end else if (item_r.kind == KIND_LOAD && !valid_r) begin
        out_nxt.status = ST_NO_VALID;
        active_nxt     = 1'b0;
        pos_nxt        = '0;
        hash_nxt       = FNV_BASIS;
        failed_nxt     = 1'b0;
      end else begin
        if (restart && item_r.kind == KIND_SAVE) begin
          valid_nxt = 1'b0;
        end
        if (pos_eff < POS_FULL) begin
          if (item_r.kind == KIND_SAVE) begin
            wr_en = 1'b1;
          end else begin
            out_nxt.byte_out = rd_data_r;
          end
          hash_eff = fnv_step(hash_eff, hash_byte);
          pos_eff  = pos_eff + 1'b1;
        end else begin
          failed_eff = 1'b1;
        end
        out_nxt.hash_out = hash_eff;
        if (item_r.last) begin
          if (failed_eff || pos_eff != POS_FULL) begin
            out_nxt.status = ST_RUN_ERR;
          end else if (item_r.kind == KIND_SAVE) begin
            stored_hash_nxt = hash_eff;
            valid_nxt       = 1'b1;
          end else if (hash_eff != stored_hash_r) begin
            out_nxt.status = ST_MISMATCH;
          end
          active_nxt = 1'b0;
          pos_nxt    = '0;
          hash_nxt   = FNV_BASIS;
          failed_nxt = 1'b0;
        end else begin
          if (failed_eff) begin
            out_nxt.status = ST_RUN_ERR;
          end
          active_nxt   = 1'b1;
          run_kind_nxt = item_r.kind;
          pos_nxt      = pos_eff;
          hash_nxt     = hash_eff;
          failed_nxt   = failed_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r    <= in_data;
      rd_data_r <= mem[rd_pos[AW-1:0]];
    end
    if (cmd.execute && wr_en) begin
      mem[pos_r[AW-1:0] & {AW{!restart}}] <= item_r.byte_in;
    end
    if (cmd.execute) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_hash_r <= '0;
      valid_r       <= 1'b0;
      pos_r         <= '0;
      hash_r        <= FNV_BASIS;
      failed_r      <= 1'b0;
      active_r      <= 1'b0;
      run_kind_r    <= KIND_SAVE;
    end else if (cmd.execute) begin
      stored_hash_r <= stored_hash_nxt;
      valid_r       <= valid_nxt;
      pos_r         <= pos_nxt;
      hash_r        <= hash_nxt;
      failed_r      <= failed_nxt;
      active_r      <= active_nxt;
      run_kind_r    <= run_kind_nxt;
    end
  end

  assign out_data = out_r;

endmodule
